[hdl/tmu_pkg.sv]
package tmu_pkg;

	typedef enum logic [2:0] {
		CMD_IDENTITY  = 3'd0,
		CMD_WRITE     = 3'd1,
		CMD_TRANSLATE = 3'd2,
		CMD_ROT_X     = 3'd3,
		CMD_ROT_Y     = 3'd4,
		CMD_ROT_Z     = 3'd5,
		CMD_SCALE     = 3'd6,
		CMD_READ      = 3'd7
	} cmd_t;

	localparam int CORDIC_FRAC = 30;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
	localparam logic [127:0] RAD_TO_DEG_Q32 = 128'd246083499208;
	localparam int ATAN_BITS = 48;

	// atan(2^-i) in degrees with 32 fraction bits, evaluated at elaboration
	function automatic logic [ATAN_BITS-1:0] atan_deg(input int i);
		logic [127:0] sum;
		logic [127:0] quo;
		logic [127:0] rem;
		logic [127:0] prod;
		int k;
		int e;
		int b;
		int den;
		if (i == 0) begin
			return ATAN_BITS'(45) << 32;
		end
		sum = '0;
		for (k = 0; k < 31; k++) begin
			e = 60 - i * (2 * k + 1);
			if (e >= 0) begin
				den = 2 * k + 1;
				quo = '0;
				rem = '0;
				for (b = 60; b >= 0; b--) begin
					rem = (rem << 1) | ((b == e) ? 128'd1 : 128'd0);
					if (rem >= 128'(den)) begin
						rem = rem - 128'(den);
						quo[b] = 1'b1;
					end
				end
				if (k % 2 == 1) begin
					sum = sum - quo;
				end else begin
					sum = sum + quo;
				end
			end
		end
		prod = sum * RAD_TO_DEG_Q32;
		return prod[60 +: ATAN_BITS];
	endfunction

endpackage

[hdl/tmu_trig.sv]
module tmu_trig #(
	parameter int FRACTION_BITS = 16,
	parameter int TRIG_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [31:0]           angle,
	output logic                         done,
	output logic signed [FRACTION_BITS+1:0] cos_val,
	output logic signed [FRACTION_BITS+1:0] sin_val
);

	localparam int CW = FRACTION_BITS + 2;
	localparam int XW = 34;
	localparam int DW = 44;
	localparam int IW = (TRIG_STEPS > 1) ? $clog2(TRIG_STEPS) : 1;
	localparam int SH = tmu_pkg::CORDIC_FRAC - FRACTION_BITS;
	localparam logic [71:0] PERIOD = 72'(360) << FRACTION_BITS;
	localparam logic signed [DW-1:0] HALF = DW'(180) <<< 32;
	localparam logic signed [DW-1:0] QUARTER = DW'(90) <<< 32;
	localparam logic signed [DW-1:0] FULL = DW'(360) <<< 32;
	localparam logic signed [XW:0] RND = (XW+1)'(1) <<< ((SH > 0) ? SH - 1 : 0);
	localparam logic signed [XW:0] ONE = (XW+1)'(1) <<< FRACTION_BITS;

	typedef logic [tmu_pkg::ATAN_BITS-1:0] atan_arr_t [TRIG_STEPS];

	function automatic atan_arr_t build_atan();
		atan_arr_t t;
		for (int n = 0; n < TRIG_STEPS; n++) begin
			t[n] = tmu_pkg::atan_deg(n);
		end
		return t;
	endfunction

	localparam atan_arr_t ATAN = build_atan();

	function automatic logic signed [CW-1:0] to_frac(input logic signed [XW-1:0] v);
		logic signed [XW:0] t;
		t = (XW+1)'(v);
		if (SH > 0) begin
			t = (t + RND) >>> SH;
		end
		if (t > ONE) begin
			t = ONE;
		end
		if (t < -ONE) begin
			t = -ONE;
		end
		return CW'(t);
	endfunction

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_RED  = 5'b00010,
		T_FOLD = 5'b00100,
		T_ROT  = 5'b01000,
		T_FIN  = 5'b10000
	} tstate_t;

	tstate_t state_q;
	logic [4:0] k_q;
	logic [IW-1:0] i_q;
	logic neg_in_q;
	logic neg_q;
	logic [71:0] mag_q;
	logic signed [DW-1:0] d_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic done_q;
	logic signed [CW-1:0] cos_q;
	logic signed [CW-1:0] sin_q;

	logic [71:0] cmp;
	logic [71:0] r_red;
	logic signed [DW-1:0] d_raw;
	logic signed [DW-1:0] d_fold;
	logic neg_fold;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [DW-1:0] atan_i;

	always_comb begin
		cmp = PERIOD << k_q;
		r_red = (neg_in_q && mag_q != '0) ? PERIOD - mag_q : mag_q;
		d_raw = DW'(r_red) <<< (32 - FRACTION_BITS);
		if (d_raw > HALF) begin
			d_raw = d_raw - FULL;
		end
		d_fold = d_raw;
		neg_fold = 1'b0;
		if (d_raw > QUARTER) begin
			d_fold = d_raw - HALF;
			neg_fold = 1'b1;
		end else if (d_raw < -QUARTER) begin
			d_fold = d_raw + HALF;
			neg_fold = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		atan_i = DW'(ATAN[i_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						neg_in_q <= angle[31];
						mag_q <= angle[31] ? 72'(-(33'(angle))) : 72'(angle);
						k_q <= 5'd31;
						state_q <= T_RED;
					end
				end
				T_RED: begin
					if (mag_q >= cmp) begin
						mag_q <= mag_q - cmp;
					end
					k_q <= k_q - 5'd1;
					if (k_q == '0) begin
						state_q <= T_FOLD;
					end
				end
				T_FOLD: begin
					d_q <= d_fold;
					neg_q <= neg_fold;
					x_q <= tmu_pkg::CORDIC_K;
					y_q <= '0;
					i_q <= '0;
					state_q <= T_ROT;
				end
				T_ROT: begin
					if (d_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						d_q <= d_q - atan_i;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						d_q <= d_q + atan_i;
					end
					i_q <= i_q + IW'(1);
					if (i_q == IW'(TRIG_STEPS - 1)) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					cos_q <= to_frac(neg_q ? -x_q : x_q);
					sin_q <= to_frac(neg_q ? -y_q : y_q);
					done_q <= 1'b1;
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_FIN |=> done && state_q == T_IDLE)
		else $error("trig done not raised after final step");
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_ROT && i_q == IW'(TRIG_STEPS - 1) |=> state_q == T_FIN)
		else $error("rotation count overrun");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == T_IDLE)
		else $error("done outside idle");

endmodule

[hdl/transform_matrix_unit.sv]
// identity, write, translate, read: go straight from idle to the result word
// scale: three diagonal entries through the shared multiplier
// rotate: 32 angle reduction steps, TRIG_STEPS cordic steps, then each of
// the four columns on the shared multiply-add
// throughput: one word at a time, input stalled until the result is taken
// reset: asynchronous, matrix returns to identity, no result pending
module transform_matrix_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRACTION_BITS = 16,
	parameter int TRIG_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [1:0]         column,
	input  logic [1:0]         row,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic signed [31:0] angle_deg,
	input  logic signed [31:0] scale_factor,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic               saturated
);

	localparam int W = WORD_BITS;
	localparam int CW = FRACTION_BITS + 2;
	localparam int MW = (W > CW) ? W : CW;
	localparam int PW = 2 * MW + 1;
	localparam logic signed [W-1:0] ONE_W = W'(1) <<< FRACTION_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_TRIG = 6'b000010,
		S_LDA  = 6'b000100,
		S_LDB  = 6'b001000,
		S_MUL  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	function automatic logic [W:0] sat_w(input logic signed [PW-1:0] v);
		logic signed [W-1:0] mx;
		mx = {1'b0, {(W-1){1'b1}}};
		if (v > PW'(mx)) begin
			return {1'b1, mx};
		end else if (v < PW'(~mx)) begin
			return {1'b1, ~mx};
		end
		return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic [32:0] sat_rd(input logic signed [W-1:0] v);
		logic signed [63:0] t;
		t = 64'(v);
		if (t > 64'sd2147483647) begin
			return {1'b1, 32'h7fffffff};
		end else if (t < -64'sd2147483648) begin
			return {1'b1, 32'h80000000};
		end
		return {1'b0, t[31:0]};
	endfunction

	state_t state_q;
	tmu_pkg::cmd_t cmd_q;
	logic trig_start;
	logic trig_done;
	logic signed [W-1:0] mat_q [16];
	logic [1:0] col_q;
	logic [1:0] ra_q;
	logic [1:0] rb_q;
	logic [2:0] ph_q;
	logic signed [W-1:0] a_q;
	logic signed [W-1:0] b_q;
	logic signed [MW-1:0] p_q;
	logic signed [MW-1:0] q_q;
	logic signed [MW-1:0] u_q;
	logic signed [MW-1:0] v_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic flag_q;
	logic signed [31:0] rd_q;

	logic signed [CW-1:0] cos_v;
	logic signed [CW-1:0] sin_v;
	logic signed [MW-1:0] op_a;
	logic signed [MW-1:0] op_b;
	logic signed [2*MW-1:0] mprod;
	logic [W:0] sat_mix;
	logic [W:0] sat_scl;
	logic [W:0] sat_elem;
	logic [W:0] sat_fac;
	logic [W:0] sat_sh [3];
	logic [W:0] sat_tr [3];
	logic [32:0] rd_sat;
	logic [3:0] addr_a;
	logic is_scale;
	tmu_pkg::cmd_t cmd_in;
	logic signed [31:0] shifts [3];

	assign cmd_in = tmu_pkg::cmd_t'(command);
	assign is_scale = (cmd_q == tmu_pkg::CMD_SCALE);
	assign addr_a = is_scale ? {col_q, col_q} : {col_q, ra_q};
	assign shifts[0] = shift_x;
	assign shifts[1] = shift_y;
	assign shifts[2] = shift_z;

	always_comb begin
		trig_start = 1'b0;
		if (state_q == S_IDLE && in_valid) begin
			trig_start = (cmd_in == tmu_pkg::CMD_ROT_X) || (cmd_in == tmu_pkg::CMD_ROT_Y)
				|| (cmd_in == tmu_pkg::CMD_ROT_Z);
		end
		case (ph_q)
			3'd1: begin
				op_a = q_q;
				op_b = MW'(b_q);
			end
			3'd2: begin
				op_a = u_q;
				op_b = MW'(a_q);
			end
			3'd3: begin
				op_a = v_q;
				op_b = MW'(b_q);
			end
			default: begin
				op_a = p_q;
				op_b = MW'(a_q);
			end
		endcase
		mprod = op_a * op_b;
		sat_mix = sat_w((acc_q + prod_q) >>> FRACTION_BITS);
		sat_scl = sat_w(prod_q >>> FRACTION_BITS);
		sat_elem = sat_w(PW'(elem_value));
		sat_fac = sat_w(PW'(scale_factor));
		for (int n = 0; n < 3; n++) begin
			sat_sh[n] = sat_w(PW'(shifts[n]));
			sat_tr[n] = sat_w(PW'(mat_q[12 + n]) + PW'($signed(sat_sh[n][W-1:0])));
		end
		rd_sat = sat_rd(mat_q[{column, row}]);
	end

	tmu_trig #(
		.FRACTION_BITS(FRACTION_BITS),
		.TRIG_STEPS(TRIG_STEPS)
	) u_trig (
		.clk(clk),
		.arst_n(arst_n),
		.start(trig_start),
		.angle(angle_deg),
		.done(trig_done),
		.cos_val(cos_v),
		.sin_val(sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int n = 0; n < 16; n++) begin
				mat_q[n] <= (n % 5 == 0) ? ONE_W : '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd_in;
						flag_q <= 1'b0;
						rd_q <= '0;
						col_q <= '0;
						ph_q <= '0;
						unique case (cmd_in)
							tmu_pkg::CMD_IDENTITY: begin
								for (int n = 0; n < 16; n++) begin
									mat_q[n] <= (n % 5 == 0) ? ONE_W : '0;
								end
								state_q <= S_OUT;
							end
							tmu_pkg::CMD_WRITE: begin
								mat_q[{column, row}] <= sat_elem[W-1:0];
								flag_q <= sat_elem[W];
								state_q <= S_OUT;
							end
							tmu_pkg::CMD_TRANSLATE: begin
								for (int n = 0; n < 3; n++) begin
									mat_q[12 + n] <= sat_tr[n][W-1:0];
								end
								flag_q <= sat_sh[0][W] | sat_sh[1][W] | sat_sh[2][W]
									| sat_tr[0][W] | sat_tr[1][W] | sat_tr[2][W];
								state_q <= S_OUT;
							end
							tmu_pkg::CMD_ROT_X: begin
								ra_q <= 2'd1;
								rb_q <= 2'd2;
								state_q <= S_TRIG;
							end
							tmu_pkg::CMD_ROT_Y: begin
								ra_q <= 2'd0;
								rb_q <= 2'd2;
								state_q <= S_TRIG;
							end
							tmu_pkg::CMD_ROT_Z: begin
								ra_q <= 2'd0;
								rb_q <= 2'd1;
								state_q <= S_TRIG;
							end
							tmu_pkg::CMD_SCALE: begin
								p_q <= MW'($signed(sat_fac[W-1:0]));
								flag_q <= sat_fac[W];
								state_q <= S_LDA;
							end
							tmu_pkg::CMD_READ: begin
								rd_q <= rd_sat[31:0];
								flag_q <= rd_sat[32];
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_TRIG: begin
					if (trig_done) begin
						p_q <= MW'(cos_v);
						v_q <= MW'(cos_v);
						if (cmd_q == tmu_pkg::CMD_ROT_Y) begin
							q_q <= MW'(sin_v);
							u_q <= -MW'(sin_v);
						end else begin
							q_q <= -MW'(sin_v);
							u_q <= MW'(sin_v);
						end
						state_q <= S_LDA;
					end
				end
				S_LDA: begin
					a_q <= mat_q[addr_a];
					ph_q <= '0;
					state_q <= is_scale ? S_MUL : S_LDB;
				end
				S_LDB: begin
					b_q <= mat_q[{col_q, rb_q}];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= PW'(mprod);
					ph_q <= ph_q + 3'd1;
					if (is_scale) begin
						if (ph_q == 3'd1) begin
							mat_q[addr_a] <= sat_scl[W-1:0];
							flag_q <= flag_q | sat_scl[W];
							col_q <= col_q + 2'd1;
							state_q <= (col_q == 2'd2) ? S_OUT : S_LDA;
						end
					end else begin
						case (ph_q)
							3'd1, 3'd3: begin
								acc_q <= prod_q;
							end
							3'd2: begin
								mat_q[addr_a] <= sat_mix[W-1:0];
								flag_q <= flag_q | sat_mix[W];
							end
							3'd4: begin
								mat_q[{col_q, rb_q}] <= sat_mix[W-1:0];
								flag_q <= flag_q | sat_mix[W];
								col_q <= col_q + 2'd1;
								state_q <= (col_q == 2'd3) ? S_OUT : S_LDA;
							end
							default: begin
							end
						endcase
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign read_value = rd_q;
	assign saturated = flag_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result word repeated");
	a_trig_wait: assert property (@(posedge clk) disable iff (!arst_n)
		trig_done |-> state_q == S_TRIG)
		else $error("trig finished outside wait state");
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_q != tmu_pkg::CMD_READ |-> read_value == '0)
		else $error("nonzero read value on non-read word");

endmodule
